FILE: design/qpht_pkg.sv
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared constants, codes and controller/datapath interface types for the
// quadratic-probe hash table.
// ----------------------------------------------------------------------------
package qpht_pkg;

   // Table geometry. The table size is a power of two, so the slot number of a
   // probe is the low bits of a running sum.
   localparam int TABLE_SIZE = 16;
   localparam int MAX_PROBES = 16;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int STEP_W     = $clog2(MAX_PROBES + 1);

   // Field widths.
   localparam int ACTION_W = 2;
   localparam int KEY_W    = 31;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load;         // capture key, set home slot, step one
      logic                read;         // read the current slot
      logic                advance;      // move to the next probe slot
      logic                write_key;    // store the key in the current slot
      logic                write_clear;  // mark the current slot empty
      logic                respond;      // present a result transaction
      logic                use_slot;     // result carries the current slot
      logic [STATUS_W-1:0] status;       // result status code
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_key_zero;  // incoming key is zero
      logic held_empty;    // slot just read is empty
      logic held_match;    // slot just read holds the key
      logic last_probe;    // current probe is the last one allowed
   } dp_stat_type;

endpackage

FILE: design/quadratic_probe_hash_table_top.sv
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_top
// Open-addressed hash table whose probe offsets are running sums of squares: insert, search, delete.
//
//   Channel   Ports                                   Transfer
//   request   start, busy, req_action, req_key_value  start && !busy
//   response  rsp_valid, rsp_status, rsp_slot_index   rsp_valid, one cycle
//
// Each probe passes through a read state and a check state: the slot read is registered, then compared.
// An operation of p probes (1 to 16) keeps busy high from the accepting edge
// until the result strobes in the cycle busy falls; a new command can be
// accepted in that same cycle. A zero key or unused action answers in the
// next cycle without going busy. Reset empties all slots at once and drops any
// pending operation. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [qpht_pkg::ACTION_W-1:0]  req_action,
   input  logic [qpht_pkg::KEY_W-1:0]     req_key_value,
   output logic                           rsp_valid,
   output logic [qpht_pkg::STATUS_W-1:0]  rsp_status,
   output logic [qpht_pkg::SLOT_W-1:0]    rsp_slot_index
);
   import qpht_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequencer.
   qpht_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy)
   );

   // Storage, probe arithmetic and result registers.
   qpht_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_key_value  (req_key_value),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index)
   );

endmodule

FILE: design/qpht_datapath.sv
// ----------------------------------------------------------------------------
// qpht_datapath
// Slot storage, probe address sequencing, key compare and result registers.
// ----------------------------------------------------------------------------
module qpht_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [qpht_pkg::KEY_W-1:0]   req_key_value,
   input  qpht_pkg::dp_cmd_type         cmd,
   output qpht_pkg::dp_stat_type        stat,
   output logic                         rsp_valid,
   output logic [qpht_pkg::STATUS_W-1:0] rsp_status,
   output logic [qpht_pkg::SLOT_W-1:0]  rsp_slot_index
);
   import qpht_pkg::*;

   logic [KEY_W-1:0]      key_ff, key_in;
   logic [IDX_W-1:0]      addr_ff, addr_in;
   logic [IDX_W-1:0]      sq_ff, sq_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [KEY_W-1:0]      slot_mem_ff [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] valid_ff;
   logic [KEY_W-1:0]      rd_data_ff;
   logic                  rd_valid_ff;
   logic                  rsp_valid_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;

   // Probe sequencing: the squared step is kept modulo the table size and
   // grows by 2*step+1 each probe.
   always_comb begin
      key_in  = key_ff;
      addr_in = addr_ff;
      sq_in   = sq_ff;
      step_in = step_ff;
      if (cmd.load) begin
         key_in  = req_key_value;
         addr_in = req_key_value[IDX_W-1:0];
         sq_in   = IDX_W'(1);
         step_in = STEP_W'(1);
      end else if (cmd.advance) begin
         addr_in = addr_ff + sq_ff;
         sq_in   = sq_ff + {step_ff[IDX_W-2:0], 1'b1};
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      addr_ff <= addr_in;
      sq_ff   <= sq_in;
      step_ff <= step_in;
   end

   // Slot storage with registered read; the valid bits give the empty state.
   always_ff @(posedge clock) begin
      if (cmd.write_key) begin
         slot_mem_ff[addr_ff] <= key_ff;
      end
      if (cmd.read) begin
         rd_data_ff <= slot_mem_ff[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.write_key) begin
            valid_ff[addr_ff] <= 1'b1;
         end else if (cmd.write_clear) begin
            valid_ff[addr_ff] <= 1'b0;
         end
         if (cmd.read) begin
            rd_valid_ff <= valid_ff[addr_ff];
         end
      end
   end

   // Status back to the controller.
   always_comb begin
      stat.req_key_zero = (req_key_value == '0);
      stat.held_empty   = !rd_valid_ff;
      stat.held_match   = rd_valid_ff && (rd_data_ff == key_ff);
      stat.last_probe   = (step_ff == STEP_W'(MAX_PROBES));
   end

   // Result registers: one strobed transaction per operation.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_status_ff <= cmd.status;
         rsp_slot_ff   <= cmd.use_slot ? SLOT_W'(addr_ff) : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

endmodule

FILE: design/qpht_controller.sv
// ----------------------------------------------------------------------------
// qpht_controller
// Operation sequencer: accepts a command, walks the probe sequence one slot
// at a time and decides insert, search and delete outcomes.
// ----------------------------------------------------------------------------
module qpht_controller (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [qpht_pkg::ACTION_W-1:0] req_action,
   input  qpht_pkg::dp_stat_type         stat,
   output qpht_pkg::dp_cmd_type          cmd,
   output logic                          busy
);
   import qpht_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_READ  = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [ACTION_W-1:0] action_ff, action_in;

   // Next state and datapath commands.
   always_comb begin
      state_in  = state_ff;
      action_in = action_ff;
      cmd       = '0;
      cmd.status = ST_NOT_FOUND;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_action == ACT_UNUSED || stat.req_key_zero) begin
                  // Nothing to look up: answer at once.
                  cmd.respond = 1'b1;
                  cmd.status  = ST_NOT_FOUND;
               end else begin
                  cmd.load  = 1'b1;
                  action_in = req_action;
                  state_in  = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (action_ff == ACT_INSERT) begin
               if (stat.held_empty) begin
                  cmd.write_key = 1'b1;
                  cmd.respond   = 1'b1;
                  cmd.use_slot  = 1'b1;
                  cmd.status    = ST_OK;
                  state_in      = S_IDLE;
               end else if (stat.last_probe) begin
                  cmd.respond = 1'b1;
                  cmd.status  = ST_FULL;
                  state_in    = S_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = S_READ;
               end
            end else begin
               if (stat.held_match) begin
                  cmd.write_clear = (action_ff == ACT_DELETE);
                  cmd.respond     = 1'b1;
                  cmd.use_slot    = 1'b1;
                  cmd.status      = ST_OK;
                  state_in        = S_IDLE;
               end else if (stat.held_empty || stat.last_probe) begin
                  cmd.respond = 1'b1;
                  cmd.status  = ST_NOT_FOUND;
                  state_in    = S_IDLE;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
   end

   assign busy = (state_ff != S_IDLE);

endmodule

FILE: design/qpht_checker.sv
// ----------------------------------------------------------------------------
// qpht_checker
// Port-level checks on the hash table's command and response transactions.
// ----------------------------------------------------------------------------
module qpht_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic [qpht_pkg::ACTION_W-1:0]  req_action,
   input logic [qpht_pkg::KEY_W-1:0]     req_key_value,
   input logic                           rsp_valid,
   input logic [qpht_pkg::STATUS_W-1:0]  rsp_status,
   input logic [qpht_pkg::SLOT_W-1:0]    rsp_slot_index
);
   import qpht_pkg::*;

   // A response carries a defined status code.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_NOT_FOUND ||
                     rsp_status == ST_FULL))
      else $error("response with undefined status");

   // A failed transaction reports slot zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> (rsp_slot_index == '0))
      else $error("nonzero slot on failed transaction");

   // A zero key or unused action is answered as not found in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_UNUSED || req_key_value == '0))
      |=> (rsp_valid && rsp_status == ST_NOT_FOUND && !busy))
      else $error("trivial command not answered at once");

   // The response closes the operation: the block is no longer busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   // Busy only starts after an accepted command.
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a command");

endmodule

bind quadratic_probe_hash_table_top qpht_checker u_qpht_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_action     (req_action),
   .req_key_value  (req_key_value),
   .rsp_valid      (rsp_valid),
   .rsp_status     (rsp_status),
   .rsp_slot_index (rsp_slot_index)
);
